// ===== sv/h264fua_pkg.sv =====
// Shared types and constants for the H.264 RTP FU-A packetizer.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
package h264fua_pkg;

  // Field widths of the configuration registers, header fields and configuration port.
  localparam int PT_W    = 7;
  localparam int SSRC_W  = 32;
  localparam int STEP_W  = 17;
  localparam int MAXP_W  = 11;
  localparam int SEQ_W   = 16;
  localparam int TS_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_RTP_PT         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SSRC_ID        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMESTAMP_STEP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD    = 2'd3;

  // Register values after reset.
  localparam logic [PT_W-1:0]   PT_RESET   = 7'd96;
  localparam logic [SSRC_W-1:0] SSRC_RESET = 32'd10;
  localparam logic [STEP_W-1:0] STEP_RESET = 17'd3600;
  localparam logic [MAXP_W-1:0] MAXP_RESET = 11'd1400;

  // Smallest usable payload size; smaller settings act as this.
  localparam logic [MAXP_W-1:0] MAXP_FLOOR = 11'd2;

  // Fixed header bits.
  localparam logic [7:0] RTP_VER_BYTE = 8'h80;
  localparam logic [4:0] FU_A_TYPE    = 5'd28;
  localparam logic [7:0] NRI_MASK     = 8'he0;
  localparam logic [7:0] TYPE_MASK    = 8'h1f;
  localparam logic [7:0] FU_START_BIT = 8'h80;
  localparam logic [7:0] FU_END_BIT   = 8'h40;

  // Command queue depth (a power of two, so the pointers wrap naturally).
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One classified input item: what the back end has to send for it.
  typedef struct packed {
    logic              hdr;      // send the 12-byte RTP header
    logic              fu;       // send FU indicator and FU header
    logic              pay;      // send the NAL byte itself
    logic              marker;
    logic [PT_W-1:0]   pt;
    logic [SEQ_W-1:0]  seq;
    logic [TS_W-1:0]   ts;
    logic [SSRC_W-1:0] ssrc;
    logic [7:0]        fu_ind;
    logic [7:0]        fu_hdr;
    logic [7:0]        data;
    logic              pend;     // the NAL byte closes its packet
  } cmd_t;

  // Byte slot within the output of one command.
  typedef enum logic [3:0] {
    PH_VER, PH_PT, PH_SEQ_HI, PH_SEQ_LO,
    PH_TS3, PH_TS2, PH_TS1, PH_TS0,
    PH_SSRC3, PH_SSRC2, PH_SSRC1, PH_SSRC0,
    PH_FU_IND, PH_FU_HDR, PH_PAY
  } phase_t;

endpackage

// ===== sv/h264fua_front.sv =====
// Front end of the packetizer: configuration registers, per-unit tracking
// state, and classification of each input byte into a back-end command.
// Depends on h264fua_pkg.
module h264fua_front import h264fua_pkg::*; #(
  parameter int LENGTH_BITS = 17
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             nal_byte,
  input  logic                   nal_first,
  input  logic [LENGTH_BITS-1:0] nal_length,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   q_full,
  output logic                   push,
  output cmd_t                   cmd
);

  logic [PT_W-1:0]        rtp_pt;
  logic [SSRC_W-1:0]      ssrc_id;
  logic [STEP_W-1:0]      timestamp_step;
  logic [MAXP_W-1:0]      max_payload;

  logic [SEQ_W-1:0]       seq, seq_next;
  logic [TS_W-1:0]        ts, ts_next;
  logic [7:0]             saved_hdr, saved_hdr_next;
  logic [LENGTH_BITS-1:0] latched_len, latched_len_next;
  logic [LENGTH_BITS-1:0] pos, pos_next;
  logic [MAXP_W-1:0]      fill, fill_next;
  logic                   frag, frag_next;

  logic                   accept;
  logic [MAXP_W-1:0]      eff_max;
  logic [LENGTH_BITS-1:0] eff_max_ext;
  logic [LENGTH_BITS-1:0] rem;
  logic                   last_frag;
  logic [MAXP_W-1:0]      fill_cur;

  // The front end stalls only when the queue has no room.
  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rtp_pt         <= PT_RESET;
      ssrc_id        <= SSRC_RESET;
      timestamp_step <= STEP_RESET;
      max_payload    <= MAXP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RTP_PT:         rtp_pt         <= cfg_data[PT_W-1:0];
        CFG_SSRC_ID:        ssrc_id        <= cfg_data[SSRC_W-1:0];
        CFG_TIMESTAMP_STEP: timestamp_step <= cfg_data[STEP_W-1:0];
        CFG_MAX_PAYLOAD:    max_payload    <= cfg_data[MAXP_W-1:0];
        default: ;
      endcase
    end
  end

  // Fragment sizing: remaining bytes and whether they fit in one fragment.
  assign eff_max     = (max_payload < MAXP_FLOOR) ? MAXP_FLOOR : max_payload;
  assign eff_max_ext = LENGTH_BITS'(eff_max);
  assign rem         = latched_len - pos;
  assign last_frag   = (rem <= eff_max_ext);
  assign fill_cur    = (fill != '0) ? fill : (last_frag ? rem[MAXP_W-1:0] : eff_max);

  // Classification of the current byte and the next tracking state.
  always_comb begin
    seq_next         = seq;
    ts_next          = ts;
    saved_hdr_next   = saved_hdr;
    latched_len_next = latched_len;
    pos_next         = pos;
    fill_next        = fill;
    frag_next        = frag;
    push             = 1'b0;

    cmd        = '0;
    cmd.pt     = rtp_pt;
    cmd.ssrc   = ssrc_id;
    cmd.data   = nal_byte;
    cmd.seq    = seq + 1'b1;

    if (nal_first) begin
      ts_next          = ts + TS_W'(timestamp_step);
      latched_len_next = nal_length;
      pos_next         = '0;
      fill_next        = '0;
      frag_next        = 1'b0;
      cmd.ts           = ts_next;
      if (nal_length != '0) begin
        saved_hdr_next = nal_byte;
        pos_next       = LENGTH_BITS'(1);
        seq_next       = seq + 1'b1;
        push           = 1'b1;
        cmd.hdr        = 1'b1;
        if (nal_length <= eff_max_ext) begin
          // Whole unit in a single packet.
          cmd.pay  = 1'b1;
          cmd.pend = (nal_length == LENGTH_BITS'(1));
        end else begin
          // First fragment: the header byte is folded into the FU bytes.
          frag_next  = 1'b1;
          cmd.fu     = 1'b1;
          cmd.fu_ind = (nal_byte & NRI_MASK) | {3'b000, FU_A_TYPE};
          cmd.fu_hdr = FU_START_BIT | (nal_byte & TYPE_MASK);
          fill_next  = eff_max - 1'b1;
        end
      end
    end else begin
      cmd.ts = ts;
      if (pos < latched_len) begin
        push     = 1'b1;
        cmd.pay  = 1'b1;
        pos_next = pos + 1'b1;
        if (!frag) begin
          cmd.pend = (pos_next == latched_len);
        end else begin
          if (fill == '0) begin
            // This byte opens a later fragment.
            seq_next   = seq + 1'b1;
            cmd.hdr    = 1'b1;
            cmd.fu     = 1'b1;
            cmd.marker = last_frag;
            cmd.fu_ind = (saved_hdr & NRI_MASK) | {3'b000, FU_A_TYPE};
            cmd.fu_hdr = (last_frag ? FU_END_BIT : 8'h00) | (saved_hdr & TYPE_MASK);
          end
          cmd.pend  = (fill_cur == MAXP_W'(1));
          fill_next = fill_cur - 1'b1;
        end
      end
    end

    if (!accept) begin
      seq_next         = seq;
      ts_next          = ts;
      saved_hdr_next   = saved_hdr;
      latched_len_next = latched_len;
      pos_next         = pos;
      fill_next        = fill;
      frag_next        = frag;
      push             = 1'b0;
    end
  end

  // Tracking state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq         <= '0;
      ts          <= '0;
      latched_len <= '0;
      pos         <= '0;
      fill        <= '0;
      frag        <= 1'b0;
    end else begin
      seq         <= seq_next;
      ts          <= ts_next;
      latched_len <= latched_len_next;
      pos         <= pos_next;
      fill        <= fill_next;
      frag        <= frag_next;
    end
  end

  // The saved NAL header is payload and needs no reset.
  always_ff @(posedge clk) begin
    saved_hdr <= saved_hdr_next;
  end

endmodule

// ===== sv/h264fua_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on h264fua_pkg.
module h264fua_queue import h264fua_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t cmd_in,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t cmd_out
);

  cmd_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign valid   = (count != '0);
  assign cmd_out = mem[rd_ptr];

  // Pointer and occupancy tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= cmd_in;
  end

endmodule

// ===== sv/h264fua_back.sv =====
// Back end of the packetizer: byte sequencer that expands one command into
// header, FU and payload bytes, with a registered output stage.
// Depends on h264fua_pkg.
module h264fua_back import h264fua_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       packet_end,
  output logic       run_end
);

  cmd_t       cur;
  logic       cur_valid;
  phase_t     phase;
  phase_t     phase_next;
  phase_t     start_phase;
  logic       adv;
  logic       fire;
  logic       cur_last;
  logic [7:0] byte_sel;

  // The output register can take a byte when it is empty or being drained.
  assign adv      = !out_valid || out_ready;
  assign fire     = cur_valid && adv;
  assign cur_last = cur.pay ? (phase == PH_PAY) : (phase == PH_FU_HDR);
  assign pop      = q_valid && (!cur_valid || (fire && cur_last));

  assign start_phase = q_cmd.hdr ? PH_VER : PH_PAY;

  // Slot order: RTP header if any, then FU bytes if fragmenting, then the NAL byte if any.
  always_comb begin
    if (phase == PH_SSRC0 && !cur.fu) begin
      phase_next = PH_PAY;
    end else begin
      phase_next = phase_t'(phase + 1'b1);
    end
  end

  // Byte selection for the current slot.
  always_comb begin
    case (phase)
      PH_VER:    byte_sel = RTP_VER_BYTE;
      PH_PT:     byte_sel = {cur.marker, cur.pt};
      PH_SEQ_HI: byte_sel = cur.seq[15:8];
      PH_SEQ_LO: byte_sel = cur.seq[7:0];
      PH_TS3:    byte_sel = cur.ts[31:24];
      PH_TS2:    byte_sel = cur.ts[23:16];
      PH_TS1:    byte_sel = cur.ts[15:8];
      PH_TS0:    byte_sel = cur.ts[7:0];
      PH_SSRC3:  byte_sel = cur.ssrc[31:24];
      PH_SSRC2:  byte_sel = cur.ssrc[23:16];
      PH_SSRC1:  byte_sel = cur.ssrc[15:8];
      PH_SSRC0:  byte_sel = cur.ssrc[7:0];
      PH_FU_IND: byte_sel = cur.fu_ind;
      PH_FU_HDR: byte_sel = cur.fu_hdr;
      PH_PAY:    byte_sel = cur.data;
      default:   byte_sel = cur.data;
    endcase
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= PH_VER;
    end else if (pop) begin
      cur_valid <= 1'b1;
      phase     <= start_phase;
    end else if (fire && cur_last) begin
      cur_valid <= 1'b0;
    end else if (fire) begin
      phase <= phase_next;
    end
  end

  // Current command payload.
  always_ff @(posedge clk) begin
    if (pop) cur <= q_cmd;
  end

  // Output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte   <= byte_sel;
      packet_end <= (phase == PH_PAY) && cur.pend;
      run_end    <= cur_last;
    end
  end

  // A packet can only close on the last byte that an input item causes.
  a_pend_is_run_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_end |-> run_end)
    else $error("packet_end without run_end");

  // A command without an RTP header only ever sits at the payload slot.
  a_nohdr_payload: assert property (@(posedge clk) disable iff (rst)
    cur_valid && !cur.hdr |-> phase == PH_PAY)
    else $error("header slot reached for a payload-only command");

  // FU slots are never visited for an unfragmented packet.
  a_no_fu_slots: assert property (@(posedge clk) disable iff (rst)
    cur_valid && !cur.fu |-> phase != PH_FU_IND && phase != PH_FU_HDR)
    else $error("FU slot reached for an unfragmented command");

  // A command with no NAL byte must be a fragment start with FU bytes.
  a_nopay_has_fu: assert property (@(posedge clk) disable iff (rst)
    cur_valid && !cur.pay |-> cur.fu && cur.hdr)
    else $error("command without payload lacks FU header");

endmodule

// ===== sv/h264_rtp_fua_packetizer.sv =====
// H.264 RTP packetizer with FU-A fragmentation, one NAL byte per transfer in.
// Path: an input transfer goes through the command queue, the current-command
// register and the output register. Throughput: one output byte per cycle
// while out_ready is high; the back-end sequencer prefixes header and FU bytes.
// Reset (synchronous): counters and queue clear, registers return to defaults.
// Depends on h264fua_pkg, h264fua_front, h264fua_queue and h264fua_back.
module h264_rtp_fua_packetizer import h264fua_pkg::*; #(
  parameter int LENGTH_BITS = 17
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             nal_byte,
  input  logic                   nal_first,
  input  logic [LENGTH_BITS-1:0] nal_length,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   packet_end,
  output logic                   run_end,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic q_valid;
  cmd_t q_cmd;

  // Classifies each input transfer into a command.
  h264fua_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .nal_byte  (nal_byte),
    .nal_first (nal_first),
    .nal_length(nal_length),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  // Decouples the front end from the byte sequencer.
  h264fua_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .cmd_in (push_cmd),
    .full   (q_full),
    .pop    (pop),
    .valid  (q_valid),
    .cmd_out(q_cmd)
  );

  // Expands commands into packet bytes.
  h264fua_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .packet_end(packet_end),
    .run_end   (run_end)
  );

endmodule
